// ----- hw/rtl/cnls_pkg.sv -----
// shared types and constants for the nmt / lss slave core
`timescale 1ns / 1ps
`default_nettype none
package cnls_pkg;

    // node states
    localparam logic [1:0] NS_INIT  = 2'd0;
    localparam logic [1:0] NS_PREOP = 2'd1;
    localparam logic [1:0] NS_OPER  = 2'd2;
    localparam logic [1:0] NS_STOP  = 2'd3;

    // event codes
    localparam logic [2:0] EV_NONE    = 3'd0;
    localparam logic [2:0] EV_START   = 3'd1;
    localparam logic [2:0] EV_STOP    = 3'd2;
    localparam logic [2:0] EV_PREOP   = 3'd3;
    localparam logic [2:0] EV_RSTNODE = 3'd4;
    localparam logic [2:0] EV_RSTCOMM = 3'd5;
    localparam logic [2:0] EV_IDENT   = 3'd6;
    localparam logic [2:0] EV_NCIDENT = 3'd7;

    // identifiers
    localparam logic [10:0] LSS_TX_ID = 11'h7E4;
    localparam logic [10:0] LSS_RX_ID = 11'h7E5;
    localparam logic [10:0] BOOT_BASE = 11'h700;
    localparam logic [7:0]  ID_NONE   = 8'hFF;
    localparam logic [3:0]  BAUD_NONE = 4'd15;

    // register indexes
    localparam logic [2:0] REG_VENDOR  = 3'd0;
    localparam logic [2:0] REG_PRODUCT = 3'd1;
    localparam logic [2:0] REG_REV     = 3'd2;
    localparam logic [2:0] REG_SERIAL  = 3'd3;
    localparam logic [2:0] REG_INITID  = 3'd4;
    localparam logic [2:0] REG_STORE   = 3'd5;

    // item kinds from the front end
    typedef enum logic [1:0] {
        K_NONE = 2'd0,
        K_INIT = 2'd1,
        K_NMT  = 2'd2,
        K_LSS  = 2'd3
    } kind_t;

    // classified item passed through the queue
    typedef struct packed {
        kind_t       kind;
        logic [63:0] payload;
    } cmd_t;

    // result item
    typedef struct packed {
        logic        tx_valid;
        logic [10:0] tx_cob_id;
        logic [3:0]  tx_length;
        logic [63:0] tx_payload;
        logic [1:0]  node_state_now;
        logic [7:0]  node_id_now;
        logic        lss_config_mode;
        logic [3:0]  requested_baud;
        logic [2:0]  event_code;
    } res_t;

endpackage
`default_nettype wire

// ----- hw/rtl/canopen_nmt_lss_slave_core.sv -----
// top level: nmt and lss slave core
// an input transaction reaches the result through the queue, then the output register
// throughput: one frame per cycle unless the result channel stalls, set by the back-end state update
// two-entry queue decouples the front end from a stalled result channel
// reset: synchronous, active low; node in initialisation, node id 255, baud 15
// every input transaction yields exactly one result transaction
`timescale 1ns / 1ps
`default_nettype none
module canopen_nmt_lss_slave_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [79:0] s_tdata,   // rx_cob_id, rx_remote, rx_length, rx_payload
    input  wire logic        s_tuser,   // operation
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [103:0] m_tdata,       // tx_valid, tx_cob_id, tx_length, tx_payload,
                                        // node_state_now, node_id_now, lss_config_mode,
                                        // requested_baud, zero fill
    output logic [2:0]       m_tuser,   // event_code
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);
    import cnls_pkg::*;

    logic q_valid, q_ready;
    cmd_t q_cmd;
    res_t res;

    assign cfg_ready = 1'b1;

    cnls_front u_front (
        .aclk, .aresetn,
        .in_valid(s_tvalid), .in_ready(s_tready),
        .operation(s_tuser), .cob_id(s_tdata[10:0]), .remote(s_tdata[11]),
        .length(s_tdata[15:12]), .payload(s_tdata[79:16]),
        .q_valid, .q_ready, .q_cmd
    );

    cnls_back u_back (
        .aclk, .aresetn,
        .q_valid, .q_ready, .q_cmd,
        .cfg_valid, .cfg_index, .cfg_data,
        .out_valid(m_tvalid), .out_ready(m_tready), .out_res(res)
    );

    // result packing
    assign m_tdata = {9'd0, res.requested_baud, res.lss_config_mode, res.node_id_now,
                      res.node_state_now, res.tx_payload, res.tx_length, res.tx_cob_id,
                      res.tx_valid};
    assign m_tuser = res.event_code;
endmodule
`default_nettype wire

// ----- hw/rtl/cnls_front.sv -----
// front end: accepts frames, classifies them and queues commands
`timescale 1ns / 1ps
`default_nettype none
module cnls_front (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire logic           operation,
    input  wire logic [10:0]    cob_id,
    input  wire logic           remote,
    input  wire logic [3:0]     length,
    input  wire logic [63:0]    payload,
    output logic                q_valid,
    input  wire logic           q_ready,
    output cnls_pkg::cmd_t      q_cmd
);
    import cnls_pkg::*;

    cmd_t fifo [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    cmd_t       cls;
    logic       push, pop;

    // classification
    always_comb begin
        cls.payload = payload;
        if (operation)                          cls.kind = K_INIT;
        else if (cob_id[10:7] == 4'd0)
            cls.kind = (!remote && length >= 4'd2) ? K_NMT : K_NONE;
        else if (cob_id == LSS_RX_ID && length == 4'd8) cls.kind = K_LSS;
        else                                    cls.kind = K_NONE;
    end

    assign in_ready = (cnt_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign pop      = q_valid && q_ready;
    assign q_cmd    = fifo[rd_ptr_reg];

    // two-entry queue storage
    always_ff @(posedge aclk) begin
        if (push) fifo[wr_ptr_reg] <= cls;
    end

    // queue pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule
`default_nettype wire

// ----- hw/rtl/cnls_back.sv -----
// back end: nmt and lss state, response framing, output register
`timescale 1ns / 1ps
`default_nettype none
module cnls_back (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           q_valid,
    output logic                q_ready,
    input  wire cnls_pkg::cmd_t q_cmd,
    input  wire logic           cfg_valid,
    input  wire logic [2:0]     cfg_index,
    input  wire logic [31:0]    cfg_data,
    output logic                out_valid,
    input  wire logic           out_ready,
    output cnls_pkg::res_t      out_res
);
    import cnls_pkg::*;

    logic [31:0] vendor_reg, product_reg, rev_reg, serial_reg;
    logic        store_reg;
    logic [1:0]  state_reg, state_next;
    logic [7:0]  id_reg, id_next, pend_reg, pend_next;
    logic        mode_reg, mode_next;
    logic [3:0]  sel_reg, sel_next;
    logic [5:0]  idm_reg, idm_next;
    logic [3:0]  baud_reg, baud_next;
    logic        ov_reg;
    res_t        res_reg, res_next;
    logic        fire;

    logic [7:0]  cs, b1, b2;
    logic [31:0] v, ident;
    logic [1:0]  isel;
    logic        ok, cfgm;
    logic [5:0]  idm_new;
    logic [3:0]  sel_new;

    assign q_ready   = !ov_reg || out_ready;
    assign fire      = q_valid && q_ready;
    assign out_valid = ov_reg;
    assign out_res   = res_reg;

    assign cs = q_cmd.payload[7:0];
    assign b1 = q_cmd.payload[15:8];
    assign b2 = q_cmd.payload[23:16];
    assign v  = q_cmd.payload[39:8];

    // identity index: selective switch counts from 0x40, inquiry from 0x5a
    assign isel = cs[4] ? (cs[1:0] - 2'd2) : cs[1:0];

    // identity selected by the index above
    always_comb begin
        case (isel)
            2'd0:    ident = vendor_reg;
            2'd1:    ident = product_reg;
            2'd2:    ident = rev_reg;
            default: ident = serial_reg;
        endcase
    end

    // per-command state update
    always_comb begin
        state_next = state_reg; id_next = id_reg; pend_next = pend_reg;
        mode_next = mode_reg; sel_next = sel_reg; idm_next = idm_reg;
        baud_next = baud_reg;
        res_next = '0;
        cfgm = mode_reg;
        ok = 1'b0; idm_new = idm_reg; sel_new = sel_reg;
        unique case (q_cmd.kind)
            K_INIT: begin
                state_next = NS_PREOP;
                if (id_reg != ID_NONE) begin
                    res_next.tx_valid = 1'b1;
                    res_next.tx_cob_id = BOOT_BASE | {3'd0, id_reg};
                    res_next.tx_length = 4'd1;
                end
            end
            K_NMT: begin
                if (state_reg != NS_INIT && (b1 == 8'd0 || b1 == id_reg)) begin
                    case (cs)
                        8'h01: if (state_reg == NS_PREOP || state_reg == NS_STOP) begin
                            res_next.event_code = EV_START; state_next = NS_OPER;
                        end
                        8'h02: if (state_reg == NS_PREOP || state_reg == NS_OPER) begin
                            res_next.event_code = EV_STOP; state_next = NS_STOP;
                        end
                        8'h80: if (state_reg == NS_OPER || state_reg == NS_STOP) begin
                            res_next.event_code = EV_PREOP; state_next = NS_PREOP;
                        end
                        8'h81, 8'h82: begin
                            if (cs == 8'h82 && id_reg != pend_reg && pend_reg != 8'd0
                                && pend_reg != ID_NONE) id_next = pend_reg;
                            res_next.event_code = (cs == 8'h81) ? EV_RSTNODE : EV_RSTCOMM;
                            state_next = NS_PREOP;
                            if (id_next != ID_NONE) begin
                                res_next.tx_valid = 1'b1;
                                res_next.tx_cob_id = BOOT_BASE | {3'd0, id_next};
                                res_next.tx_length = 4'd1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            K_LSS: begin
                if (state_reg == NS_PREOP || state_reg == NS_STOP) begin
                    res_next.tx_cob_id = LSS_TX_ID;
                    res_next.tx_length = 4'd8;
                    res_next.tx_payload[7:0] = cs;
                    case (cs)
                        8'h04: begin
                            if (b1 == 8'd1 && !mode_reg) mode_next = 1'b1;
                            else if (b1 == 8'd0 && mode_reg) begin
                                if (pend_reg != id_reg && id_reg == ID_NONE) begin
                                    if (pend_reg != 8'd0 && pend_reg != ID_NONE)
                                        id_next = pend_reg;
                                    state_next = NS_PREOP;
                                    if (id_next != ID_NONE) begin
                                        res_next.tx_valid = 1'b1;
                                        res_next.tx_cob_id = BOOT_BASE | {3'd0, id_next};
                                        res_next.tx_length = 4'd1;
                                        res_next.tx_payload = '0;
                                    end
                                end
                                mode_next = 1'b0;
                            end
                        end
                        8'h11: if (cfgm) begin
                            res_next.tx_valid = 1'b1;
                            if (b1 == 8'd0 || (b1 > 8'd127 && b1 != ID_NONE))
                                res_next.tx_payload[15:8] = 8'd1;
                            else pend_next = b1;
                        end
                        8'h13: if (cfgm) begin
                            res_next.tx_valid = 1'b1;
                            if (b2 <= 8'd8) baud_next = b2[3:0];
                            else res_next.tx_payload[15:8] = 8'hFF;
                        end
                        8'h17: if (cfgm) begin
                            res_next.tx_valid = 1'b1;
                            res_next.tx_payload[15:8] = {7'd0, !store_reg};
                        end
                        8'h40, 8'h41, 8'h42, 8'h43: if (!cfgm) begin
                            if (ident == v) begin
                                sel_new = sel_reg | (4'd1 << cs[1:0]);
                                if (sel_new == 4'hF) begin
                                    sel_next = 4'd0; pend_next = id_reg; mode_next = 1'b1;
                                    res_next.tx_valid = 1'b1;
                                    res_next.tx_payload[7:0] = 8'h44;
                                end else sel_next = sel_new;
                            end else sel_next = 4'd0;
                        end
                        8'h46, 8'h47, 8'h48, 8'h49, 8'h4A, 8'h4B: begin
                            case (cs)
                                8'h46:   ok = vendor_reg == v;
                                8'h47:   ok = product_reg == v;
                                8'h48:   ok = rev_reg >= v;
                                8'h49:   ok = rev_reg <= v;
                                8'h4A:   ok = serial_reg >= v;
                                default: ok = serial_reg <= v;
                            endcase
                            idm_new = ok ? (idm_reg | (6'd1 << (cs[2:0] - 3'd6))) : 6'd0;
                            if (idm_new == 6'h3F) begin
                                idm_next = 6'd0;
                                res_next.event_code = EV_IDENT;
                                res_next.tx_valid = 1'b1;
                                res_next.tx_payload[7:0] = 8'h4F;
                            end else idm_next = idm_new;
                        end
                        8'h4C: if (id_reg == ID_NONE) begin
                            res_next.event_code = EV_NCIDENT;
                            res_next.tx_valid = 1'b1;
                            res_next.tx_payload[7:0] = 8'h50;
                        end
                        8'h5A, 8'h5B, 8'h5C, 8'h5D: if (cfgm) begin
                            res_next.tx_valid = 1'b1;
                            res_next.tx_payload[39:8] = ident;
                        end
                        8'h5E: if (cfgm) begin
                            res_next.tx_valid = 1'b1;
                            res_next.tx_payload[15:8] = id_reg;
                        end
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase
        // frame fields are zero when nothing is sent
        if (!res_next.tx_valid) begin
            res_next.tx_cob_id = '0; res_next.tx_length = '0; res_next.tx_payload = '0;
        end
        res_next.node_state_now  = state_next;
        res_next.node_id_now     = id_next;
        res_next.lss_config_mode = mode_next;
        res_next.requested_baud  = baud_next;
    end

    // output register
    always_ff @(posedge aclk) begin
        if (fire) res_reg <= res_next;
    end

    // control and node state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ov_reg <= 1'b0;
            vendor_reg <= '0; product_reg <= '0; rev_reg <= '0; serial_reg <= '0;
            store_reg <= 1'b0;
            state_reg <= NS_INIT; id_reg <= ID_NONE; pend_reg <= ID_NONE;
            mode_reg <= 1'b0; sel_reg <= '0; idm_reg <= '0; baud_reg <= BAUD_NONE;
        end else begin
            if (fire) ov_reg <= 1'b1;
            else if (out_ready) ov_reg <= 1'b0;
            if (fire) begin
                state_reg <= state_next; id_reg <= id_next; pend_reg <= pend_next;
                mode_reg <= mode_next; sel_reg <= sel_next; idm_reg <= idm_next;
                baud_reg <= baud_next;
            end
            // configuration writes
            if (cfg_valid) begin
                unique case (cfg_index)
                    REG_VENDOR:  vendor_reg  <= cfg_data;
                    REG_PRODUCT: product_reg <= cfg_data;
                    REG_REV:     rev_reg     <= cfg_data;
                    REG_SERIAL:  serial_reg  <= cfg_data;
                    REG_INITID: begin
                        if (state_reg == NS_INIT) begin
                            id_reg   <= (cfg_data[7:0] == 8'd0) ? ID_NONE : cfg_data[7:0];
                            pend_reg <= (cfg_data[7:0] == 8'd0) ? ID_NONE : cfg_data[7:0];
                        end
                    end
                    REG_STORE:   store_reg   <= cfg_data[0];
                    default: ;
                endcase
            end
        end
    end
endmodule
`default_nettype wire

// ----- tb/canopen_nmt_lss_slave_core_tb.sv -----
// self-checking testbench for the nmt / lss slave core: directed and random frames
`timescale 1ns / 1ps
module canopen_nmt_lss_slave_core_tb;
    import cnls_pkg::*;

    // nmt command bytes
    localparam logic [7:0] NMT_START   = 8'h01;
    localparam logic [7:0] NMT_STOP    = 8'h02;
    localparam logic [7:0] NMT_PREOP   = 8'h80;
    localparam logic [7:0] NMT_RSTNODE = 8'h81;
    localparam logic [7:0] NMT_RSTCOMM = 8'h82;

    // lss command specifiers
    localparam logic [7:0] CS_SWITCH    = 8'h04;
    localparam logic [7:0] CS_CFG_ID    = 8'h11;
    localparam logic [7:0] CS_CFG_BIT   = 8'h13;
    localparam logic [7:0] CS_ACTIVATE  = 8'h15;
    localparam logic [7:0] CS_STORE     = 8'h17;
    localparam logic [7:0] CS_SEL_VEND  = 8'h40;
    localparam logic [7:0] CS_SEL_SER   = 8'h43;
    localparam logic [7:0] CS_SEL_ACK   = 8'h44;
    localparam logic [7:0] CS_IDN_VEND  = 8'h46;
    localparam logic [7:0] CS_IDN_SER_H = 8'h4B;
    localparam logic [7:0] CS_IDN_ACK   = 8'h4F;
    localparam logic [7:0] CS_NONCONF   = 8'h4C;
    localparam logic [7:0] CS_NC_ACK    = 8'h50;
    localparam logic [7:0] CS_INQ_VEND  = 8'h5A;
    localparam logic [7:0] CS_INQ_ID    = 8'h5E;

    localparam int WATCHDOG_LIMIT = 4000;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [79:0]  s_tdata = '0;
    logic         s_tuser = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [103:0] m_tdata;
    logic [2:0]   m_tuser;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [2:0]   cfg_index = '0;
    logic [31:0]  cfg_data = '0;

    canopen_nmt_lss_slave_core u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // node mirror: identity registers and slave state
    logic [31:0] id_vendor = '0, id_product = '0, id_rev = '0, id_serial = '0;
    logic [7:0]  init_id_reg = ID_NONE;
    logic        store_ok = 1'b0;
    logic [1:0]  node_st = NS_INIT;
    logic [7:0]  node_id = ID_NONE, pending_id = ID_NONE;
    logic        cfg_mode = 1'b0;
    logic [3:0]  sel_mask = '0;
    logic [5:0]  idn_mask = '0;
    logic [3:0]  baud_req = BAUD_NONE;
    res_t        frame_out;

    res_t expected_status[$];
    int   error_count = 0;
    int   frames_sent = 0;
    int   status_seen = 0;
    int   idle_pct = 0;
    int   stall_pct = 0;

    function automatic logic [31:0] identity_word(logic [1:0] k);
        case (k)
            2'd0: return id_vendor;
            2'd1: return id_product;
            2'd2: return id_rev;
            default: return id_serial;
        endcase
    endfunction

    function automatic void boot_up();
        node_st = NS_PREOP;
        if (node_id != ID_NONE) begin
            frame_out.tx_valid   = 1'b1;
            frame_out.tx_cob_id  = BOOT_BASE | {3'b000, node_id};
            frame_out.tx_length  = 4'd1;
            frame_out.tx_payload = '0;
        end
    endfunction

    function automatic void lss_answer(logic [7:0] cs, logic [55:0] rest);
        frame_out.tx_valid   = 1'b1;
        frame_out.tx_cob_id  = LSS_TX_ID;
        frame_out.tx_length  = 4'd8;
        frame_out.tx_payload = {rest, cs};
    endfunction

    function automatic void adopt_pending();
        if (pending_id != 8'd0 && pending_id != ID_NONE) node_id = pending_id;
    endfunction

    function automatic void nmt_command(logic [63:0] pay);
        logic [7:0] cmd;
        logic [7:0] tgt;
        cmd = pay[7:0];
        tgt = pay[15:8];
        if (node_st == NS_INIT || (tgt != 8'd0 && tgt != node_id)) return;
        case (cmd)
            NMT_START: if (node_st == NS_PREOP || node_st == NS_STOP) begin
                frame_out.event_code = EV_START;
                node_st = NS_OPER;
            end
            NMT_STOP: if (node_st == NS_PREOP || node_st == NS_OPER) begin
                frame_out.event_code = EV_STOP;
                node_st = NS_STOP;
            end
            NMT_PREOP: if (node_st == NS_OPER || node_st == NS_STOP) begin
                frame_out.event_code = EV_PREOP;
                node_st = NS_PREOP;
            end
            NMT_RSTNODE: begin
                frame_out.event_code = EV_RSTNODE;
                boot_up();
            end
            NMT_RSTCOMM: begin
                if (node_id != pending_id) adopt_pending();
                frame_out.event_code = EV_RSTCOMM;
                boot_up();
            end
            default: ;
        endcase
    endfunction

    function automatic void lss_command(logic [63:0] pay);
        logic [7:0]  cs, b1, b2;
        logic [31:0] v;
        logic        hit;
        cs  = pay[7:0];
        b1  = pay[15:8];
        b2  = pay[23:16];
        v   = pay[39:8];
        if (cs == CS_SWITCH) begin
            if (b1 == {7'd0, cfg_mode} || b1 > 8'd1) return;
            if (b1 == 8'd1) begin
                cfg_mode = 1'b1;
                return;
            end
            // leaving configuration unconfigured: take over the new id and reboot
            if (pending_id != node_id && node_id == ID_NONE) begin
                adopt_pending();
                boot_up();
            end
            cfg_mode = 1'b0;
        end else if (cs == CS_CFG_ID) begin
            if (!cfg_mode) return;
            if (b1 == 8'd0 || (b1 > 8'd127 && b1 != ID_NONE)) lss_answer(cs, 56'd1);
            else begin
                pending_id = b1;
                lss_answer(cs, 56'd0);
            end
        end else if (cs == CS_CFG_BIT) begin
            if (!cfg_mode) return;
            if (b2 <= 8'd8) begin
                baud_req = b2[3:0];
                lss_answer(cs, 56'd0);
            end else lss_answer(cs, 56'hFF);
        end else if (cs == CS_STORE) begin
            if (cfg_mode) lss_answer(cs, store_ok ? 56'd0 : 56'd1);
        end else if (cs >= CS_SEL_VEND && cs <= CS_SEL_SER) begin
            if (cfg_mode) return;
            if (identity_word(cs[1:0]) == v) begin
                sel_mask = sel_mask | (4'd1 << cs[1:0]);
                if (sel_mask == 4'hF) begin
                    sel_mask   = '0;
                    pending_id = node_id;
                    cfg_mode   = 1'b1;
                    lss_answer(CS_SEL_ACK, 56'd0);
                end
            end else sel_mask = '0;
        end else if (cs >= CS_IDN_VEND && cs <= CS_IDN_SER_H) begin
            case (cs - CS_IDN_VEND)
                8'd0: hit = id_vendor == v;
                8'd1: hit = id_product == v;
                8'd2: hit = id_rev >= v;
                8'd3: hit = id_rev <= v;
                8'd4: hit = id_serial >= v;
                default: hit = id_serial <= v;
            endcase
            idn_mask = hit ? (idn_mask | (6'd1 << (cs - CS_IDN_VEND))) : 6'd0;
            if (idn_mask == 6'h3F) begin
                idn_mask = '0;
                frame_out.event_code = EV_IDENT;
                lss_answer(CS_IDN_ACK, 56'd0);
            end
        end else if (cs == CS_NONCONF) begin
            if (node_id == ID_NONE) begin
                frame_out.event_code = EV_NCIDENT;
                lss_answer(CS_NC_ACK, 56'd0);
            end
        end else if (cs >= CS_INQ_VEND && cs < CS_INQ_ID) begin
            if (cfg_mode) lss_answer(cs, {24'd0, identity_word(cs[1:0] - 2'd2)});
        end else if (cs == CS_INQ_ID) begin
            if (cfg_mode) lss_answer(cs, {48'd0, node_id});
        end
    endfunction

    function automatic res_t predict_status(logic op, logic [10:0] cob, logic rem,
                                            logic [3:0] len, logic [63:0] pay);
        frame_out = '0;
        if (op) boot_up();
        else if (cob[10:7] == 4'd0) begin
            if (!rem && len >= 4'd2) nmt_command(pay);
        end else if (cob == LSS_RX_ID) begin
            if ((node_st == NS_PREOP || node_st == NS_STOP) && len == 4'd8) lss_command(pay);
        end
        frame_out.node_state_now  = node_st;
        frame_out.node_id_now     = node_id;
        frame_out.lss_config_mode = cfg_mode;
        frame_out.requested_baud  = baud_req;
        return frame_out;
    endfunction

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        error_count++;
        $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
    endtask

    // one frame on the input channel, with random idle cycles ahead of it
    task automatic send_frame(logic op, logic [10:0] cob, logic rem, logic [3:0] len,
                              logic [63:0] pay);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {pay, len, rem, cob};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_status.push_back(predict_status(op, cob, rem, len, pay));
        frames_sent++;
    endtask

    task automatic send_lss(logic [7:0] cs, logic [31:0] v);
        send_frame(1'b0, LSS_RX_ID, 1'b0, 4'd8, {24'd0, v, cs});
    endtask

    task automatic send_nmt(logic [7:0] cmd, logic [7:0] tgt);
        send_frame(1'b0, 11'd0, 1'b0, 4'd2, {48'd0, tgt, cmd});
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_status.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // register write; cfg_valid is lowered by the caller once the batch is done
    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            REG_VENDOR:  id_vendor = val;
            REG_PRODUCT: id_product = val;
            REG_REV:     id_rev = val;
            REG_SERIAL:  id_serial = val;
            REG_INITID: begin
                init_id_reg = val[7:0];
                if (node_st == NS_INIT) begin
                    node_id    = (val[7:0] == 8'd0) ? ID_NONE : val[7:0];
                    pending_id = node_id;
                end
            end
            REG_STORE:   store_ok = val[0];
            default: ;
        endcase
    endtask

    task automatic configure(logic [31:0] ven, logic [31:0] prod, logic [31:0] rev,
                             logic [31:0] ser, logic [7:0] init_id, logic store);
        drain();
        write_reg(REG_VENDOR, ven);
        write_reg(REG_PRODUCT, prod);
        write_reg(REG_REV, rev);
        write_reg(REG_SERIAL, ser);
        write_reg(REG_INITID, {24'd0, init_id});
        write_reg(REG_STORE, {31'd0, store});
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // directed: unconfigured node, lss takeover, nmt commands and every lss service
    task automatic test_directed();
        configure(32'h1234_5678, 32'hFFFF_FFFF, 32'h0000_0010, 32'h8000_0000, ID_NONE, 1'b1);
        send_nmt(NMT_START, 8'd0);                // ignored in initialisation
        send_frame(1'b1, 11'd0, 1'b0, 4'd0, '0);  // local init, no boot-up without id
        send_lss(CS_NONCONF, 32'd0);
        send_lss(CS_SEL_VEND, id_vendor);
        send_lss(CS_SEL_VEND + 8'd1, id_product);
        send_lss(CS_SEL_VEND + 8'd2, id_rev);
        send_lss(CS_SEL_SER, id_serial);
        send_lss(CS_CFG_ID, 32'd200);             // out of range
        send_lss(CS_CFG_ID, 32'd0);
        send_lss(CS_CFG_ID, 32'd127);
        send_lss(CS_CFG_BIT, 32'h0800);
        send_lss(CS_CFG_BIT, 32'h0900);
        send_lss(CS_ACTIVATE, 32'd0);
        send_lss(CS_STORE, 32'd0);
        for (int k = 0; k < 5; k++) send_lss(CS_INQ_VEND + 8'(k), 32'd0);
        send_lss(CS_SWITCH, 32'd0);               // takeover of id 127 and boot-up
        for (int k = 0; k < 6; k++)
            send_lss(CS_IDN_VEND + 8'(k), (k < 2) ? identity_word(2'(k)) :
                     (k < 4) ? id_rev : id_serial);
        send_nmt(NMT_START, 8'd127);
        send_lss(CS_SWITCH, 32'd1);               // ignored while operational
        send_nmt(NMT_STOP, 8'd3);                 // other node
        send_frame(1'b0, 11'd0, 1'b1, 4'd2, {48'd0, 8'd0, NMT_STOP});
        send_frame(1'b0, 11'd0, 1'b0, 4'd1, {48'd0, 8'd0, NMT_STOP});
        send_nmt(NMT_STOP, 8'd0);
        send_nmt(NMT_PREOP, 8'd0);
        send_nmt(8'h55, 8'd0);
        send_nmt(NMT_RSTNODE, 8'd0);
        send_nmt(NMT_RSTCOMM, 8'd127);
        send_frame(1'b0, LSS_RX_ID, 1'b0, 4'd7, {56'd0, CS_SWITCH});
    endtask

    function automatic logic [31:0] near_value(logic [31:0] base);
        case ($urandom_range(3))
            0: return base;
            1: return base + 32'($urandom_range(3));
            2: return base - 32'($urandom_range(3));
            default: return $urandom;
        endcase
    endfunction

    task automatic random_frame();
        int pick;
        int k;
        logic [7:0] tgt;
        pick = $urandom_range(99);
        if (pick < 4) begin
            send_frame(1'b1, 11'($urandom), 1'($urandom), 4'($urandom_range(8)),
                       {$urandom, $urandom});
        end else if (pick < 28) begin
            k = $urandom_range(5);
            tgt = ($urandom_range(2) == 0) ? 8'd0 :
                  ($urandom_range(1) == 0) ? node_id : 8'($urandom);
            send_frame(1'b0, {4'd0, 7'($urandom)}, $urandom_range(9) == 0,
                       4'($urandom_range(8)), {$urandom, 16'($urandom), tgt,
                       (k == 0) ? NMT_START : (k == 1) ? NMT_STOP : (k == 2) ? NMT_PREOP :
                       (k == 3) ? NMT_RSTNODE : (k == 4) ? NMT_RSTCOMM : 8'($urandom)});
        end else if (pick < 36) begin
            // full selective switch sequence, sometimes spoiled
            for (k = 0; k < 4; k++)
                send_lss(CS_SEL_VEND + 8'(k), ($urandom_range(7) == 0) ? $urandom :
                         identity_word(2'(k)));
        end else if (pick < 42) begin
            // full identify remote sequence
            for (k = 0; k < 6; k++)
                send_lss(CS_IDN_VEND + 8'(k), (k < 2) ? near_value(identity_word(2'(k))) :
                         (k < 4) ? near_value(id_rev) : near_value(id_serial));
        end else if (pick < 88) begin
            k = $urandom_range(9);
            case (k)
                0: send_lss(CS_SWITCH, {24'd0, ($urandom_range(5) == 0) ? 8'($urandom) :
                                        8'($urandom_range(1))});
                1: send_lss(CS_CFG_ID, {24'd0, ($urandom_range(1) == 0) ?
                                        8'($urandom_range(127)) : 8'($urandom)});
                2: send_lss(CS_CFG_BIT, {16'd0, 8'($urandom_range(12)), 8'($urandom)});
                3: send_lss(CS_STORE, $urandom);
                4: send_lss(CS_INQ_VEND + 8'($urandom_range(4)), $urandom);
                5: send_lss(CS_NONCONF, $urandom);
                6: send_lss(CS_SEL_VEND + 8'($urandom_range(3)), identity_word(2'($urandom)));
                7: send_lss(CS_IDN_VEND + 8'($urandom_range(5)), near_value(id_rev));
                8: send_frame(1'b0, LSS_RX_ID, 1'($urandom), 4'($urandom_range(8)),
                              {$urandom, $urandom});
                default: send_frame(1'b0, LSS_RX_ID, 1'($urandom), 4'd8,
                                    {$urandom, $urandom});
            endcase
        end else begin
            send_frame(1'b0, 11'($urandom), 1'($urandom), 4'($urandom_range(8)),
                       {$urandom, $urandom});
        end
    endtask

    task automatic test_random_phase(int n, int idle, int stall);
        idle_pct  = idle;
        stall_pct = stall;
        for (int i = 0; i < n; i++) random_frame();
    endtask

    // result channel: random back-pressure, field checks and watchdog
    int quiet_cycles = 0;
    always @(posedge aclk) begin
        res_t got;
        res_t want;
        m_tready <= ($urandom_range(99) >= stall_pct);
        if (aresetn && m_tvalid && m_tready) begin
            got.tx_valid        = m_tdata[0];
            got.tx_cob_id       = m_tdata[11:1];
            got.tx_length       = m_tdata[15:12];
            got.tx_payload      = m_tdata[79:16];
            got.node_state_now  = m_tdata[81:80];
            got.node_id_now     = m_tdata[89:82];
            got.lss_config_mode = m_tdata[90];
            got.requested_baud  = m_tdata[94:91];
            got.event_code      = m_tuser;
            status_seen++;
            if (expected_status.size() == 0) begin
                report("unexpected transaction", 64'(got.node_state_now), 64'd0);
            end else begin
                want = expected_status.pop_front();
                if (got.tx_valid !== want.tx_valid)
                    report("tx_valid", 64'(got.tx_valid), 64'(want.tx_valid));
                if (got.tx_cob_id !== want.tx_cob_id)
                    report("tx_cob_id", 64'(got.tx_cob_id), 64'(want.tx_cob_id));
                if (got.tx_length !== want.tx_length)
                    report("tx_length", 64'(got.tx_length), 64'(want.tx_length));
                if (got.tx_payload !== want.tx_payload)
                    report("tx_payload", got.tx_payload, want.tx_payload);
                if (got.node_state_now !== want.node_state_now)
                    report("node_state_now", 64'(got.node_state_now),
                           64'(want.node_state_now));
                if (got.node_id_now !== want.node_id_now)
                    report("node_id_now", 64'(got.node_id_now), 64'(want.node_id_now));
                if (got.lss_config_mode !== want.lss_config_mode)
                    report("lss_config_mode", 64'(got.lss_config_mode),
                           64'(want.lss_config_mode));
                if (got.requested_baud !== want.requested_baud)
                    report("requested_baud", 64'(got.requested_baud),
                           64'(want.requested_baud));
                if (got.event_code !== want.event_code)
                    report("event_code", 64'(got.event_code), 64'(want.event_code));
            end
        end
        if ((m_tvalid && m_tready) || (s_tvalid && s_tready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("canopen_nmt_lss_slave_core_tb: errors");
            $finish;
        end
    end

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd1, 1'b0);
        test_random_phase(80, 0, 0);
        configure($urandom, $urandom, $urandom, $urandom, 8'($urandom_range(1, 255)), 1'b1);
        test_random_phase(80, 75, 0);
        configure('0, '0, '0, '0, 8'd255, 1'b0);
        test_random_phase(80, 0, 75);
        configure(32'($urandom_range(15)), $urandom, 32'($urandom_range(15)),
                  32'($urandom_range(15)), 8'd127, 1'b1);
        test_random_phase(80, 31, 31);
        drain();
        repeat (8) @(posedge aclk);
        $display("sent %0d frames (directed and four random phases with varying back-pressure),",
                 frames_sent);
        $display("checked %0d status transactions across five identity settings", status_seen);
        if (error_count == 0 && expected_status.size() == 0) begin
            $display("canopen_nmt_lss_slave_core_tb: clean");
        end else begin
            $display("%0d mismatches, %0d results missing", error_count,
                     expected_status.size());
            $display("canopen_nmt_lss_slave_core_tb: errors");
        end
        $finish;
    end

endmodule

// ----- canopen_nmt_lss_slave_core.f -----
hw/rtl/cnls_pkg.sv
hw/rtl/cnls_front.sv
hw/rtl/cnls_back.sv
hw/rtl/canopen_nmt_lss_slave_core.sv
tb/canopen_nmt_lss_slave_core_tb.sv
